>>> design/mpsr_pkg.sv
`timescale 1ns / 1ps

package mpsr_pkg;

  // Matrix geometry
  localparam int unsigned NUM_COLS = 4;
  localparam int unsigned COL_W    = 2;
  localparam int unsigned ROW_W    = 6;
  localparam logic [COL_W-1:0] LAST_COL = 2'd3;

  // Settle counter and register widths
  localparam int unsigned CNT_W    = 16;
  localparam int unsigned SETTLE_W = 16;
  localparam int unsigned CMP_W    = ((CNT_W > SETTLE_W) ? CNT_W : SETTLE_W) + 1;
  localparam logic [SETTLE_W-1:0] SETTLE_RESET = 16'd2;

  // Configuration map
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] REG_SETTLE_TICKS = 2'd0;

  // Axis codes
  localparam logic [7:0] AXIS_CENTER = 8'h80;
  localparam logic [7:0] AXIS_MIN    = 8'h00;
  localparam logic [7:0] AXIS_MAX    = 8'hff;

  // Row bit positions within one column sample
  localparam int unsigned ROW_FIRE  = 0;  // option / C / B / A
  localparam int unsigned ROW_PAUSE = 1;
  localparam int unsigned ROW_R2    = 2;  // 9 / 8 / 7 / south
  localparam int unsigned ROW_R3    = 3;  // 6 / 5 / 4 / west
  localparam int unsigned ROW_R4    = 4;  // 3 / 2 / 1 / east
  localparam int unsigned ROW_R5    = 5;  // hash / 0 / star / north

  typedef logic [ROW_W-1:0] sample_t;

  typedef struct packed {
    logic       hi;
    logic [7:0] mid;
    logic [7:0] lo;
    logic [7:0] y;
    logic [7:0] x;
  } report_t;

  localparam report_t REPORT_RESET = '{hi: 1'b0, mid: 8'h00, lo: 8'h00,
                                       y: AXIS_CENTER, x: AXIS_CENTER};
  localparam report_t REPORT_ZERO  = '{hi: 1'b0, mid: 8'h00, lo: 8'h00,
                                       y: 8'h00, x: 8'h00};

endpackage

>>> design/mpsr_decode.sv
`timescale 1ns / 1ps

module mpsr_decode (
  input  mpsr_pkg::sample_t c0,
  input  mpsr_pkg::sample_t c1,
  input  mpsr_pkg::sample_t c2,
  input  mpsr_pkg::sample_t c3,
  output mpsr_pkg::report_t report
);

  // Rows are active low: invert once, then a 1 means pressed.
  mpsr_pkg::sample_t p0, p1, p2, p3;

  assign p0 = ~c0;
  assign p1 = ~c1;
  assign p2 = ~c2;
  assign p3 = ~c3;

  always_comb begin
    report = mpsr_pkg::REPORT_RESET;

    // West beats east, north beats south.
    if (p3[mpsr_pkg::ROW_R3]) begin
      report.x = mpsr_pkg::AXIS_MIN;
    end else if (p3[mpsr_pkg::ROW_R4]) begin
      report.x = mpsr_pkg::AXIS_MAX;
    end
    if (p3[mpsr_pkg::ROW_R5]) begin
      report.y = mpsr_pkg::AXIS_MIN;
    end else if (p3[mpsr_pkg::ROW_R2]) begin
      report.y = mpsr_pkg::AXIS_MAX;
    end

    report.lo = {p0[mpsr_pkg::ROW_R4], p1[mpsr_pkg::ROW_R4], p2[mpsr_pkg::ROW_R4],
                 p3[mpsr_pkg::ROW_PAUSE],
                 p0[mpsr_pkg::ROW_FIRE], p1[mpsr_pkg::ROW_FIRE],
                 p2[mpsr_pkg::ROW_FIRE], p3[mpsr_pkg::ROW_FIRE]};

    report.mid = {p1[mpsr_pkg::ROW_R5], p2[mpsr_pkg::ROW_R5],
                  p0[mpsr_pkg::ROW_R2], p1[mpsr_pkg::ROW_R2], p2[mpsr_pkg::ROW_R2],
                  p0[mpsr_pkg::ROW_R3], p1[mpsr_pkg::ROW_R3], p2[mpsr_pkg::ROW_R3]};

    report.hi = p0[mpsr_pkg::ROW_R5];
  end

endmodule

>>> design/matrix_pad_scan_report_core.sv
`timescale 1ns / 1ps
// An accepted input beat yields its result beat in the next cycle.
// Throughput: one beat per cycle while out_tready holds; the result register frees
// itself when the consumer takes its beat in the same cycle, so input never waits on decode.
// Reset (rst_n low, synchronous): column 0, count 0, report centered with no
// buttons, first-scan flag set, settle_ticks back to 2, result channel empty.

module matrix_pad_scan_report_core (
  input  logic                                 clk,
  input  logic                                 rst_n,

  // Tick channel
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [7:0]                           in_tdata,   // [5:0] row_lines, [7:6] zero

  // Result channel
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [3:0] column_drive_n, [11:4] x_axis, [19:12] y_axis, [27:20] buttons_low,
  // [35:28] buttons_mid, [36] buttons_high, [39:37] zero
  output logic [39:0]                          out_tdata,
  output logic                                 out_tuser,  // [0] report_ready

  // Configuration port
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [mpsr_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [mpsr_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  output logic [mpsr_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                 cfg_pready
);

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic [mpsr_pkg::SETTLE_W-1:0] settle_ticks_r, settle_ticks_nxt;
  logic                          cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_comb begin
    settle_ticks_nxt = settle_ticks_r;
    if (cfg_wr && (cfg_paddr == mpsr_pkg::REG_SETTLE_TICKS)) begin
      settle_ticks_nxt = cfg_pwdata[mpsr_pkg::SETTLE_W-1:0];
    end
  end

  always_comb begin
    unique case (cfg_paddr)
      mpsr_pkg::REG_SETTLE_TICKS:
        cfg_prdata = {{(mpsr_pkg::CFG_DATA_W - mpsr_pkg::SETTLE_W){1'b0}}, settle_ticks_r};
      default: cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Handshake: take a beat whenever the result register is empty or drains.
  // ---------------------------------------------------------------------------
  logic out_valid_r, out_valid_nxt;
  logic accept;

  assign in_tready = ~out_valid_r | out_tready;
  assign accept    = in_tvalid & in_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Scan state
  // ---------------------------------------------------------------------------
  logic [mpsr_pkg::COL_W-1:0] col_r, col_nxt;
  logic [mpsr_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                       first_r, first_nxt;
  mpsr_pkg::report_t          report_r, report_nxt;
  mpsr_pkg::report_t          last_r, last_nxt;
  logic [mpsr_pkg::NUM_COLS-1:0] drive_r, drive_nxt;
  logic                       ready_r, ready_nxt;

  // Samples of the first three columns; the last column decodes straight
  // from the incoming rows, so it never needs storing.
  mpsr_pkg::sample_t samples_r [mpsr_pkg::NUM_COLS-1];

  mpsr_pkg::sample_t rows;
  mpsr_pkg::report_t decoded;
  logic [mpsr_pkg::CMP_W-1:0] need;
  logic [mpsr_pkg::CMP_W-1:0] cnt_inc;
  logic                       sample_now;

  assign rows = in_tdata[mpsr_pkg::ROW_W-1:0];

  // A settle time of zero behaves as one tick.
  assign need = (settle_ticks_r == '0) ? mpsr_pkg::CMP_W'(1)
                                       : mpsr_pkg::CMP_W'(settle_ticks_r);
  assign cnt_inc = mpsr_pkg::CMP_W'(cnt_r) + mpsr_pkg::CMP_W'(1);

  // Sample on the last settle tick, or when the counter saturates.
  assign sample_now = (cnt_inc >= need) || (cnt_r == {mpsr_pkg::CNT_W{1'b1}});

  mpsr_decode u_decode (
    .c0     (samples_r[0]),
    .c1     (samples_r[1]),
    .c2     (samples_r[2]),
    .c3     (rows),
    .report (decoded)
  );

  always_comb begin
    col_nxt    = col_r;
    cnt_nxt    = cnt_r;
    first_nxt  = first_r;
    report_nxt = report_r;
    last_nxt   = last_r;
    drive_nxt  = drive_r;
    ready_nxt  = ready_r;
    if (accept) begin
      // Column driven during this tick.
      drive_nxt = ~(mpsr_pkg::NUM_COLS'(1) << col_r);
      ready_nxt = 1'b0;
      if (sample_now) begin
        cnt_nxt = '0;
        col_nxt = col_r + mpsr_pkg::COL_W'(1);
        if (col_r == mpsr_pkg::LAST_COL) begin
          report_nxt = decoded;
          // Flag the report only on the first scan or when it changed.
          if (first_r || (decoded != last_r)) begin
            ready_nxt = 1'b1;
            first_nxt = 1'b0;
            last_nxt  = decoded;
          end
        end
      end else begin
        cnt_nxt = cnt_inc[mpsr_pkg::CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_ticks_r <= mpsr_pkg::SETTLE_RESET;
      out_valid_r    <= 1'b0;
      col_r          <= '0;
      cnt_r          <= '0;
      first_r        <= 1'b1;
      report_r       <= mpsr_pkg::REPORT_RESET;
      last_r         <= mpsr_pkg::REPORT_ZERO;
      drive_r        <= '1;
      ready_r        <= 1'b0;
    end else begin
      settle_ticks_r <= settle_ticks_nxt;
      out_valid_r    <= out_valid_nxt;
      col_r          <= col_nxt;
      cnt_r          <= cnt_nxt;
      first_r        <= first_nxt;
      report_r       <= report_nxt;
      last_r         <= last_nxt;
      drive_r        <= drive_nxt;
      ready_r        <= ready_nxt;
    end
  end

  // Capture rows into the sample of the column being finished.
  always_ff @(posedge clk) begin
    for (int i = 0; i < mpsr_pkg::NUM_COLS - 1; i++) begin
      if (accept && sample_now && (col_r == mpsr_pkg::COL_W'(i))) begin
        samples_r[i] <= rows;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result beat: report fields always show the current report.
  // ---------------------------------------------------------------------------
  assign out_tvalid = out_valid_r;
  assign out_tuser  = ready_r;
  assign out_tdata  = {3'b000, report_r.hi, report_r.mid, report_r.lo,
                       report_r.y, report_r.x, drive_r};

endmodule
